>>> sv/pgcb_pkg.sv
// Shared types and constants for the pixel gamma, contrast and brightness block.
`timescale 1ns / 1ps
`default_nettype none

package pgcb_pkg;

   localparam int CHAN_W = 8;
   typedef logic [CHAN_W-1:0] pix_type;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTRAST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA       = 2'd3;

   typedef struct packed {
      logic [7:0] contrast;
      logic [7:0] gamma;
      logic [7:0] brightness;   // two's complement hundredths
      logic       luma;
   } cfg_type;

   localparam logic [7:0] CONTRAST_RST   = 8'd100;
   localparam logic [7:0] GAMMA_RST      = 8'd100;
   localparam logic [7:0] BRIGHTNESS_RST = 8'd0;

   localparam int PCT      = 100;
   localparam int PCT_HALF = 50;
   localparam int PIX_MAX  = 255;

   // Pipeline layout: curve and scaling stages, then one quotient bit per stage
   localparam int DIV_STEPS = CHAN_W;
   localparam int DIV_FIRST = 13;
   localparam int NSTAGE    = DIV_FIRST + DIV_STEPS;

endpackage

`default_nettype wire

>>> sv/pgcb_req_if.sv
// Input pixel channel: valid/ready handshake with three raw channel bytes.
`timescale 1ns / 1ps
`default_nettype none

interface pgcb_req_if;
   import pgcb_pkg::*;

   logic    valid;
   logic    ready;
   pix_type chan_first;
   pix_type chan_second;
   pix_type chan_third;

   modport source (output valid, output chan_first, output chan_second, output chan_third,
                   input ready);
   modport sink   (input valid, input chan_first, input chan_second, input chan_third,
                   output ready);
endinterface

`default_nettype wire

>>> sv/pgcb_rsp_if.sv
// Result pixel channel: valid/ready handshake with three adjusted channel bytes.
`timescale 1ns / 1ps
`default_nettype none

interface pgcb_rsp_if;
   import pgcb_pkg::*;

   logic    valid;
   logic    ready;
   pix_type out_first;
   pix_type out_second;
   pix_type out_third;

   modport source (output valid, output out_first, output out_second, output out_third,
                   input ready);
   modport sink   (input valid, input out_first, input out_second, input out_third,
                   output ready);
endinterface

`default_nettype wire

>>> sv/pgcb_lane.sv
// One channel datapath: curve in fixed point, then scale, round and saturate to a byte.
`timescale 1ns / 1ps
`default_nettype none

module pgcb_lane #(
   parameter int FRAC_BITS        = 16,
   parameter int CURVE_TABLE_BITS = 8
) (
   input  wire logic                          clock,
   input  wire pgcb_pkg::cfg_type             cfg,
   input  wire logic [pgcb_pkg::NSTAGE-1:0]   en,
   input  wire pgcb_pkg::pix_type             x_in,
   input  wire pgcb_pkg::pix_type             ch_in,
   input  wire pgcb_pkg::pix_type             vd_in,
   output pgcb_pkg::pix_type                  out_byte
);
   import pgcb_pkg::*;

   typedef longint unsigned u64_type;

   localparam int F     = FRAC_BITS;
   localparam int T     = CURVE_TABLE_BITS;
   localparam int STEPS = 1 << T;

   localparam int LW   = F + 4;          // -log2 ratio, Q.F
   localparam int PW1  = LW + 8;         // times gamma
   localparam int DW1  = PW1 + 1;        // plus rounding half
   localparam int M1W  = DW1 - 6;
   localparam int UW   = F + 5;          // exponent magnitude
   localparam int NW   = UW - F;
   localparam int EW   = F + 2;          // exp table entry
   localparam int DFW  = F + 1;          // exp table step
   localparam int MW   = DFW + F;
   localparam int PW   = F + 1;          // power, at most one
   localparam int CW   = PW + 8;         // times contrast
   localparam int DW2  = F + 10;
   localparam int M2W  = DW2 - 6;
   localparam int YW   = F + 2;
   localparam int NUMW = YW + 16;
   localparam int AW   = NUMW + 1 - F;

   localparam logic [M1W-1:0] M1 = M1W'(((u64_type'(1)) << DW1) / PCT);
   localparam logic [M2W-1:0] M2 = M2W'(((u64_type'(1)) << DW2) / PCT);

   // ---------------------------------------------------------------- tables
   function automatic u64_type isqrt_c(u64_type v);
      u64_type r;
      u64_type bt;
      u64_type w;
      r  = 0;
      bt = u64_type'(1) << 62;
      w  = v;
      while (bt > w) bt = bt >> 2;
      while (bt != 0) begin
         if (w >= r + bt) begin
            w = w - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   function automatic u64_type root_q30(int k);
      u64_type r;
      int      j;
      r = u64_type'(2) << 30;
      for (j = 1; j <= k; j++) r = isqrt_c(r << 30);
      return r;
   endfunction

   function automatic u64_type q30_to_q(u64_type v);
      return (v + (u64_type'(1) << (29 - F))) >> (30 - F);
   endfunction

   function automatic u64_type log_entry(int i);
      u64_type m;
      u64_type y;
      int      k;
      m = u64_type'(STEPS + i) << (30 - T);
      y = 0;
      for (k = 1; k <= 30; k++) begin
         m = (m * m) >> 30;
         if (m >= (u64_type'(2) << 30)) begin
            m = m >> 1;
            y = y | (u64_type'(1) << (30 - k));
         end
      end
      if (i == STEPS) y = u64_type'(1) << 30;
      return q30_to_q(y);
   endfunction

   function automatic u64_type exp_entry(int i);
      u64_type prod;
      int      k;
      prod = u64_type'(1) << 30;
      for (k = 0; k < T; k++) begin
         if (((i >> k) & 1) != 0)
            prod = (prod * root_q30(T - k) + (u64_type'(1) << 29)) >> 30;
      end
      if (i == STEPS) return u64_type'(2) << F;
      return q30_to_q(prod);
   endfunction

   function automatic longint shift_round_c(longint v, int s);
      u64_type half;
      half = u64_type'(1) << (s - 1);
      if (v < 0) return -longint'((u64_type'(-v) + half) >> s);
      return longint'((u64_type'(v) + half) >> s);
   endfunction

   function automatic longint log_interp(u64_type q);
      u64_type pos;
      u64_type idx;
      u64_type rem;
      longint  a;
      longint  b;
      pos = q << T;
      idx = pos >> F;
      rem = pos & ((u64_type'(1) << F) - 1);
      if (idx >= STEPS) return longint'(log_entry(STEPS));
      a = longint'(log_entry(int'(idx)));
      b = longint'(log_entry(int'(idx) + 1));
      return a + shift_round_c((b - a) * longint'(rem), F);
   endfunction

   function automatic longint log2_byte(int x);
      int      e;
      u64_type fr;
      e = 7;
      while (e > 0 && ((x >> e) & 1) == 0) e = e - 1;
      fr = (u64_type'(x) << (F - e)) - (u64_type'(1) << F);
      return (longint'(e) << F) + log_interp(fr);
   endfunction

   function automatic longint neg_log_entry(int x);
      longint l;
      if (x == 0) return 0;
      l = log2_byte(x) - log2_byte(PIX_MAX);
      if (l > 0) l = 0;
      return -l;
   endfunction

   logic [LW-1:0] nlog_rom [256];
   logic [EW-1:0] exp_rom  [STEPS+1];

   for (genvar gi = 0; gi < 256; gi++) begin : g_nlog
      assign nlog_rom[gi] = LW'(neg_log_entry(gi));
   end
   for (genvar gi = 0; gi <= STEPS; gi++) begin : g_exp
      assign exp_rom[gi] = EW'(exp_entry(gi));
   end

   // ---------------------------------------------------------------- carried fields
   logic    [7:0] x0_ff;
   pix_type       ch_ff [0:10];
   pix_type       vd_ff [0:11];
   logic          zx_ff [1:6];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x0_ff    <= x_in;
         ch_ff[0] <= ch_in;
         vd_ff[0] <= vd_in;
      end
      if (en[1]) zx_ff[1] <= (x0_ff == '0);
   end

   for (genvar gs = 1; gs <= 11; gs++) begin : g_vd
      always_ff @(posedge clock) begin
         if (en[gs]) vd_ff[gs] <= vd_ff[gs-1];
      end
   end
   for (genvar gs = 1; gs <= 10; gs++) begin : g_ch
      always_ff @(posedge clock) begin
         if (en[gs]) ch_ff[gs] <= ch_ff[gs-1];
      end
   end
   for (genvar gs = 2; gs <= 6; gs++) begin : g_zx
      always_ff @(posedge clock) begin
         if (en[gs]) zx_ff[gs] <= zx_ff[gs-1];
      end
   end

   // ---------------------------------------------------------------- log and gamma
   logic [LW-1:0]      lneg1_ff;
   logic [PW1-1:0]     prod2_ff, prod2_in;
   logic [DW1-1:0]     pr3_ff, pr3_in, qa3_ff, qa3_in;
   logic [DW1+M1W-1:0] qfull3;
   logic [DW1-1:0]     r4;
   logic [UW-1:0]      u4_ff, u4_in;

   always_comb begin
      prod2_in = PW1'(lneg1_ff) * PW1'(cfg.gamma);
      pr3_in   = DW1'(prod2_ff) + DW1'(PCT_HALF);
      qfull3   = (DW1+M1W)'(pr3_in) * (DW1+M1W)'(M1);
      qa3_in   = DW1'(qfull3 >> DW1);
      r4       = pr3_ff - DW1'(qa3_ff * DW1'(PCT));
      u4_in    = (r4 >= DW1'(PCT)) ? UW'(qa3_ff + DW1'(1)) : UW'(qa3_ff);
   end

   always_ff @(posedge clock) begin
      if (en[1]) lneg1_ff <= nlog_rom[x0_ff];
      if (en[2]) prod2_ff <= prod2_in;
      if (en[3]) begin
         pr3_ff <= pr3_in;
         qa3_ff <= qa3_in;
      end
      if (en[4]) u4_ff <= u4_in;
   end

   // ---------------------------------------------------------------- exp2
   logic [NW-1:0]   n5_in, n5_ff, n6_ff;
   logic [F:0]      e5;
   logic [F+T:0]    pos5;
   logic [T:0]      idx5, idx5p;
   logic [F-1:0]    rem5_in, rem5_ff;
   logic [EW-1:0]   a5_in, a5_ff, a6_ff;
   logic [DFW-1:0]  d5_in, d5_ff;
   logic [MW-1:0]   m6_ff;
   logic [MW:0]     mr7;
   logic [EW-1:0]   ip7;
   logic [F+3:0]    t7;
   logic [PW-1:0]   p7_in, p7_ff;

   always_comb begin
      n5_in   = u4_ff[UW-1:F];
      e5      = {1'b1, {F{1'b0}}} - {1'b0, u4_ff[F-1:0]};
      pos5    = (F+T+1)'(e5) << T;
      idx5    = pos5[F+T:F];
      idx5p   = idx5 + (T+1)'(1);
      rem5_in = pos5[F-1:0];
      if (idx5 >= (T+1)'(STEPS)) begin
         a5_in = exp_rom[STEPS];
         d5_in = '0;
      end else begin
         a5_in = exp_rom[idx5];
         d5_in = DFW'(exp_rom[idx5p] - exp_rom[idx5]);
      end

      mr7 = (MW+1)'(m6_ff) + ((MW+1)'(1) << (F - 1));
      ip7 = a6_ff + EW'(mr7 >> F);
      t7  = (F+4)'(ip7) + ((F+4)'(1) << n6_ff);
      // shift right by n+1 with rounding; past the top bit the power rounds to zero
      if (int'(n6_ff) > F + 1) p7_in = '0;
      else                     p7_in = PW'(t7 >> ((NW+1)'(n6_ff) + (NW+1)'(1)));
      // zero input: 0^0 is one, otherwise zero
      if (zx_ff[6]) p7_in = (cfg.gamma == '0) ? PW'(1) << F : '0;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         n5_ff   <= n5_in;
         a5_ff   <= a5_in;
         d5_ff   <= d5_in;
         rem5_ff <= rem5_in;
      end
      if (en[6]) begin
         n6_ff <= n5_ff;
         a6_ff <= a5_ff;
         m6_ff <= MW'(d5_ff) * MW'(rem5_ff);
      end
      if (en[7]) p7_ff <= p7_in;
   end

   // ---------------------------------------------------------------- contrast, brightness
   logic [CW-1:0]        cp8_ff;
   logic signed [DW2-1:0] s9, bsh9;
   logic [DW2-1:0]       sr9_in, sr9_ff, qb9_in, qb9_ff, r10;
   logic [DW2+M2W-1:0]   qfull9;
   logic                 neg9_ff;
   logic [DW2-1:0]       y10_full;
   logic [YW-1:0]        y10_ff;
   logic                 z10_ff;

   always_comb begin
      bsh9     = DW2'($signed(cfg.brightness)) <<< F;
      s9       = $signed(DW2'(cp8_ff)) + bsh9;
      sr9_in   = DW2'(s9) + DW2'(PCT_HALF);
      qfull9   = (DW2+M2W)'(sr9_in) * (DW2+M2W)'(M2);
      qb9_in   = DW2'(qfull9 >> DW2);
      r10      = sr9_ff - DW2'(qb9_ff * DW2'(PCT));
      y10_full = (r10 >= DW2'(PCT)) ? qb9_ff + DW2'(1) : qb9_ff;
   end

   always_ff @(posedge clock) begin
      if (en[8]) cp8_ff <= CW'(p7_ff) * CW'(cfg.contrast);
      if (en[9]) begin
         sr9_ff  <= sr9_in;
         qb9_ff  <= qb9_in;
         neg9_ff <= s9[DW2-1];
      end
      if (en[10]) begin
         y10_ff <= YW'(y10_full);
         z10_ff <= neg9_ff || (y10_full == '0);
      end
   end

   // ---------------------------------------------------------------- scale to byte
   logic [15:0]     ch255;
   logic [NUMW-1:0] num11_ff;
   logic            z11_ff;
   logic [NUMW:0]   sum12;
   logic [AW-1:0]   a12;

   always_comb begin
      ch255 = {ch_ff[10], 8'b0} - {8'b0, ch_ff[10]};
      sum12 = (NUMW+1)'(num11_ff) + ((NUMW+1)'(vd_ff[11]) << (F - 1));
      a12   = sum12[NUMW:F];
   end

   logic [15:0]  dr_ff [0:DIV_STEPS];
   pix_type      dq_ff [0:DIV_STEPS];
   pix_type      dd_ff [0:DIV_STEPS];
   logic         ds_ff [0:DIV_STEPS];
   logic         dz_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (en[11]) begin
         num11_ff <= NUMW'(y10_ff) * NUMW'(ch255);
         z11_ff   <= z10_ff;
      end
      if (en[DIV_FIRST-1]) begin
         dr_ff[0] <= a12[15:0];
         dq_ff[0] <= '0;
         dd_ff[0] <= vd_ff[11];
         ds_ff[0] <= (a12 >= AW'({vd_ff[11], 8'b0}));
         dz_ff[0] <= z11_ff;
      end
   end

   // restoring division, one quotient bit per stage, top bit first
   for (genvar gd = 0; gd < DIV_STEPS; gd++) begin : g_div
      localparam int SH = DIV_STEPS - 1 - gd;
      logic [15:0] sub;
      logic        take;
      assign sub  = 16'(dd_ff[gd]) << SH;
      assign take = (dr_ff[gd] >= sub);
      always_ff @(posedge clock) begin
         if (en[DIV_FIRST+gd]) begin
            dr_ff[gd+1] <= take ? dr_ff[gd] - sub : dr_ff[gd];
            dq_ff[gd+1] <= dq_ff[gd] | (take ? CHAN_W'(1) << SH : '0);
            dd_ff[gd+1] <= dd_ff[gd];
            ds_ff[gd+1] <= ds_ff[gd];
            dz_ff[gd+1] <= dz_ff[gd];
         end
      end
   end

   assign out_byte = dz_ff[DIV_STEPS] ? '0 :
                     ds_ff[DIV_STEPS] ? CHAN_W'(PIX_MAX) : dq_ff[DIV_STEPS];

endmodule

`default_nettype wire

>>> sv/pixel_gamma_contrast_brightness.sv
// Top level: pixel gamma, contrast and brightness adjust, fully pipelined.
//
//  Port       Dir   Handshake      Payload
//  req_chan   in    valid/ready    chan_first, chan_second, chan_third (8 bit)
//  rsp_chan   out   valid/ready    out_first, out_second, out_third (8 bit)
//  csr_*      in    csr_we         csr_index (2 bit), csr_wdata (8 bit)
//
// One pixel per clock is accepted unless a stalled, full pipeline holds the
// input; each pixel passes through the curve stages (log table, gamma multiply,
// divide-by-100, exp table interpolation, contrast and brightness) and then the
// eight one-bit-per-stage divider steps of the scaling to a byte.
// Reset clears the stage valid bits, holds the input ready low and loads the
// register defaults; no table or memory needs a clearing pass.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and a stalled result holds without loss.
`timescale 1ns / 1ps
`default_nettype none

module pixel_gamma_contrast_brightness #(
   parameter int FRAC_BITS        = 16,
   parameter int CURVE_TABLE_BITS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pgcb_req_if.sink                               req_chan,
   pgcb_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [pgcb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [7:0]                        csr_wdata
);
   import pgcb_pkg::*;

   // ---------------------------------------------------------------- config registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.contrast   <= CONTRAST_RST;
         cfg_ff.gamma      <= GAMMA_RST;
         cfg_ff.brightness <= BRIGHTNESS_RST;
         cfg_ff.luma       <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONTRAST:   cfg_ff.contrast   <= csr_wdata;
            CSR_GAMMA:      cfg_ff.gamma      <= csr_wdata;
            CSR_BRIGHTNESS: cfg_ff.brightness <= csr_wdata;
            CSR_LUMA:       cfg_ff.luma       <= csr_wdata[0];
            default:        cfg_ff            <= cfg_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage valids
   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE-1:0] stage_en;

   // advance a stage when it holds nothing or its successor advances
   always_comb begin
      stage_en[NSTAGE-1] = !v_ff[NSTAGE-1] || rsp_chan.ready;
      for (int s = NSTAGE - 2; s >= 0; s--) stage_en[s] = !v_ff[s] || stage_en[s+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (stage_en[0]) v_ff[0] <= req_chan.valid;
         for (int s = 1; s < NSTAGE; s++) begin
            if (stage_en[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // hold off input while in reset so no transaction is taken and dropped
   assign req_chan.ready = stage_en[0] && !reset;
   assign rsp_chan.valid = v_ff[NSTAGE-1];

   // ---------------------------------------------------------------- lane setup
   // Per channel: curve input x, scale numerator ch and divisor vd.
   // Luma mode runs every lane on V = max channel and scales by ch/V; a black
   // pixel and per-channel mode use ch = vd = 1.
   pix_type vmax;
   pix_type x_in [3];
   pix_type ch_in [3];
   pix_type vd_in [3];
   pix_type chan [3];
   pix_type res [3];

   always_comb begin
      chan[0] = req_chan.chan_first;
      chan[1] = req_chan.chan_second;
      chan[2] = req_chan.chan_third;
      vmax = chan[0];
      if (chan[1] > vmax) vmax = chan[1];
      if (chan[2] > vmax) vmax = chan[2];
      for (int k = 0; k < 3; k++) begin
         if (cfg_ff.luma) begin
            x_in[k]  = vmax;
            ch_in[k] = (vmax == '0) ? CHAN_W'(1) : chan[k];
            vd_in[k] = (vmax == '0) ? CHAN_W'(1) : vmax;
         end else begin
            x_in[k]  = chan[k];
            ch_in[k] = CHAN_W'(1);
            vd_in[k] = CHAN_W'(1);
         end
      end
   end

   for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      pgcb_lane #(
         .FRAC_BITS        (FRAC_BITS),
         .CURVE_TABLE_BITS (CURVE_TABLE_BITS)
      ) u_lane (
         .clock    (clock),
         .cfg      (cfg_ff),
         .en       (stage_en),
         .x_in     (x_in[gl]),
         .ch_in    (ch_in[gl]),
         .vd_in    (vd_in[gl]),
         .out_byte (res[gl])
      );
   end

   assign rsp_chan.out_first  = res[0];
   assign rsp_chan.out_second = res[1];
   assign rsp_chan.out_third  = res[2];

endmodule

`default_nettype wire

>>> test/pixel_gamma_contrast_brightness_test.sv
// Self-checking testbench for the pixel gamma, contrast and brightness block.
`timescale 1ns / 1ps

module pixel_gamma_contrast_brightness_test;
   import pgcb_pkg::*;

   localparam int FRAC         = 16;
   localparam int TAB_BITS     = 8;
   localparam int TAB_STEPS    = 1 << TAB_BITS;
   localparam longint ONE_Q    = 64'd1 << FRAC;
   localparam int LATENCY      = 21;
   localparam int SETTLE       = LATENCY + 4;
   localparam int WATCHDOG_MAX = 5000;
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_ITEMS  = 95;

   typedef struct packed {
      pix_type first;
      pix_type second;
      pix_type third;
   } pixel_type;

   // One directed row: settings, pixel, and a hand-typed result where obvious
   typedef struct {
      cfg_type   cfg;
      pixel_type pix;
      bit        typed;
      pixel_type want;
   } row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0] csr_wdata;

   pgcb_req_if req ();
   pgcb_rsp_if rsp ();

   pixel_gamma_contrast_brightness dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Curve tables and the model's copy of the settings
   longint    log_curve [0:TAB_STEPS];
   longint    exp_curve [0:TAB_STEPS];
   cfg_type   cur_cfg;
   pixel_type pending_pixels[$];
   row_type   rows[$];

   int  mismatches;
   int  sent_count;
   int  checked_count;
   int  phase_count;
   int  quiet_cycles;
   int  stall_left;
   bit  tx_idle;
   bit  rx_idle;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- tables

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint q30_to_frac(longint unsigned v);
      return longint'((v + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
   endfunction

   // log2(1+i/256) by repeated squaring, 2^(i/256) by products of roots of two
   function automatic void build_curves();
      longint unsigned root [0:TAB_BITS];
      longint unsigned m;
      longint unsigned y;
      longint unsigned prod;
      root[0] = 64'd2 << 30;
      root[1] = int_sqrt(64'd2 << 60);
      for (int k = 2; k <= TAB_BITS; k++) root[k] = int_sqrt(root[k-1] << 30);
      for (int i = 0; i <= TAB_STEPS; i++) begin
         m = longint'(TAB_STEPS + i) << (30 - TAB_BITS);
         y = 0;
         for (int k = 1; k <= 30; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
               m = m >> 1;
               y = y | (64'd1 << (30 - k));
            end
         end
         if (i == TAB_STEPS) y = 64'd1 << 30;
         log_curve[i] = q30_to_frac(y);
      end
      for (int i = 0; i < TAB_STEPS; i++) begin
         prod = 64'd1 << 30;
         for (int k = 0; k < TAB_BITS; k++)
            if ((i >> k) & 1)
               prod = (prod * root[TAB_BITS-k] + (64'd1 << 29)) >> 30;
         exp_curve[i] = q30_to_frac(prod);
      end
      exp_curve[TAB_STEPS] = 2 * ONE_Q;
   endfunction

   // ---------------------------------------------------------------- arithmetic

   // Round half away from zero on a right shift
   function automatic longint round_shift(longint v, int s);
      longint unsigned mag;
      longint unsigned r;
      mag = (v < 0) ? longint'(-v) : v;
      r = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint round_div(longint num, longint den);
      if (num < 0) return -((-num + den / 2) / den);
      return (num + den / 2) / den;
   endfunction

   function automatic longint curve_lookup(bit use_exp, longint q);
      longint pos;
      longint idx;
      longint rem;
      longint lo;
      longint hi;
      pos = q << TAB_BITS;
      idx = pos >>> FRAC;
      rem = pos & (ONE_Q - 1);
      if (idx >= TAB_STEPS) return use_exp ? exp_curve[TAB_STEPS] : log_curve[TAB_STEPS];
      lo = use_exp ? exp_curve[idx] : log_curve[idx];
      hi = use_exp ? exp_curve[idx+1] : log_curve[idx+1];
      return lo + round_shift((hi - lo) * rem, FRAC);
   endfunction

   function automatic longint log2_pixel(pix_type x);
      int e;
      longint mant;
      e = 7;
      while (e > 0 && x[e] == 1'b0) e--;
      mant = (longint'(x) << (FRAC - e)) - ONE_Q;
      return (longint'(e) << FRAC) + curve_lookup(1'b0, mant);
   endfunction

   // contrast/100 * (x/255)^(gamma/100) + brightness/100, fixed point
   function automatic longint tone_curve(pix_type x, cfg_type c);
      longint g;
      longint gain;
      longint offs;
      longint p;
      longint l;
      longint u;
      longint n;
      longint f;
      g    = longint'(c.gamma);
      gain = longint'(c.contrast);
      offs = longint'(signed'(c.brightness));
      if (x == 0) begin
         // zero to the power zero counts as one
         p = (g == 0) ? ONE_Q : 0;
      end else begin
         l = log2_pixel(x) - log2_pixel(8'd255);
         if (l > 0) l = 0;
         u = round_div(-l * g, PCT);
         n = u >>> FRAC;
         f = u & (ONE_Q - 1);
         if (n >= 61) p = 0;
         else p = round_shift(curve_lookup(1'b1, ONE_Q - f), int'(n) + 1);
      end
      return round_div(gain * p + offs * ONE_Q, PCT);
   endfunction

   function automatic pix_type scale_to_byte(longint y, longint ch, longint v);
      longint den;
      longint r;
      if (y <= 0) return 8'd0;
      den = v << FRAC;
      r = (y * PIX_MAX * ch + den / 2) / den;
      return (r > PIX_MAX) ? 8'd255 : pix_type'(r);
   endfunction

   function automatic pixel_type adjust_pixel(pixel_type px, cfg_type c);
      pixel_type res;
      longint v;
      longint vp;
      if (c.luma) begin
         v = px.first;
         if (px.second > v) v = px.second;
         if (px.third > v) v = px.third;
         vp = tone_curve(pix_type'(v), c);
         if (v == 0) begin
            // black pixel: every channel takes the converted value
            res.first  = scale_to_byte(vp, 1, 1);
            res.second = res.first;
            res.third  = res.first;
         end else begin
            res.first  = scale_to_byte(vp, px.first, v);
            res.second = scale_to_byte(vp, px.second, v);
            res.third  = scale_to_byte(vp, px.third, v);
         end
      end else begin
         res.first  = scale_to_byte(tone_curve(px.first, c), 1, 1);
         res.second = scale_to_byte(tone_curve(px.second, c), 1, 1);
         res.third  = scale_to_byte(tone_curve(px.third, c), 1, 1);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- driving

   // Send one pixel, after a random gap if tx_idle is set; valid stays
   // high after the transaction so back-to-back pixels never drop it.
   task automatic send_pixel(pixel_type px, bit typed, pixel_type want);
      int gap;
      gap = 0;
      if (tx_idle) begin
         case ($urandom_range(0, 9))
            0, 1, 2:    gap = $urandom_range(1, 3);
            3:          gap = $urandom_range(8, 40);
            default:    gap = 0;
         endcase
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.chan_first  <= px.first;
      req.chan_second <= px.second;
      req.chan_third  <= px.third;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_pixels.push_back(typed ? want : adjust_pixel(px, cur_cfg));
      sent_count++;
   endtask

   // Drop valid, wait out every pending result, then let the pipe empty
   task automatic drain();
      req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_settings(cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_CONTRAST;
      csr_wdata <= c.contrast;
      @(posedge clock);
      csr_index <= CSR_GAMMA;
      csr_wdata <= c.gamma;
      @(posedge clock);
      csr_index <= CSR_BRIGHTNESS;
      csr_wdata <= c.brightness;
      @(posedge clock);
      // only bit 0 counts; upper bits get noise
      csr_index <= CSR_LUMA;
      csr_wdata <= {7'($urandom), c.luma};
      @(posedge clock);
      csr_we <= 1'b0;
      cur_cfg = c;
      phase_count++;
   endtask

   function automatic pix_type pick_channel();
      case ($urandom_range(0, 11))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd1;
         3:       return 8'd254;
         default: return pix_type'($urandom);
      endcase
   endfunction

   function automatic cfg_type mk_cfg(int c, int g, int b, bit l);
      cfg_type r;
      r.contrast   = 8'(c);
      r.gamma      = 8'(g);
      r.brightness = 8'(b);
      r.luma       = l;
      return r;
   endfunction

   function automatic pixel_type mk_pix(int a, int b, int c);
      pixel_type r;
      r.first  = 8'(a);
      r.second = 8'(b);
      r.third  = 8'(c);
      return r;
   endfunction

   function automatic void add_row(cfg_type c, pixel_type p, bit typed, pixel_type w);
      row_type r;
      r.cfg   = c;
      r.pix   = p;
      r.typed = typed;
      r.want  = w;
      rows.push_back(r);
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      pixel_type exp_px;
      if (reset) begin
         rsp.ready    <= 1'b0;
         stall_left   = 0;
         quiet_cycles = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_pixels.size() == 0) begin
               $display("%t: unexpected result %h %h %h", $time,
                        rsp.out_first, rsp.out_second, rsp.out_third);
               mismatches++;
            end else begin
               exp_px = pending_pixels.pop_front();
               checked_count++;
               if (rsp.out_first !== exp_px.first) begin
                  $display("%t: out_first expected %0d actual %0d", $time,
                           exp_px.first, rsp.out_first);
                  mismatches++;
               end
               if (rsp.out_second !== exp_px.second) begin
                  $display("%t: out_second expected %0d actual %0d", $time,
                           exp_px.second, rsp.out_second);
                  mismatches++;
               end
               if (rsp.out_third !== exp_px.third) begin
                  $display("%t: out_third expected %0d actual %0d", $time,
                           exp_px.third, rsp.out_third);
                  mismatches++;
               end
            end
         end
         // watchdog: any transaction on either channel, or an empty queue, resets it
         if ((rsp.valid && rsp.ready) || (req.valid && req.ready) ||
             pending_pixels.size() == 0)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%t: watchdog expired, %0d results outstanding", $time,
                     pending_pixels.size());
            $display("Mismatches found");
            $finish;
         end
         // back-pressure when rx_idle is set: mostly short stalls, a few long ones
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp.ready <= 1'b1;
            if (rx_idle && $urandom_range(0, 5) == 0)
               stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      cfg_type   dflt;
      cfg_type   c;
      pixel_type none;
      mismatches    = 0;
      sent_count    = 0;
      checked_count = 0;
      phase_count   = 0;
      tx_idle       = 1'b1;
      rx_idle       = 1'b1;
      none          = '0;
      req.valid       <= 1'b0;
      req.chan_first  <= '0;
      req.chan_second <= '0;
      req.chan_third  <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_CONTRAST;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      build_curves();
      dflt = mk_cfg(CONTRAST_RST, GAMMA_RST, BRIGHTNESS_RST, 1'b0);
      cur_cfg = dflt;

      // Directed rows; a typed result only where it follows at a glance
      add_row(dflt, mk_pix(0, 0, 0), 1, mk_pix(0, 0, 0));
      add_row(dflt, mk_pix(255, 255, 255), 1, mk_pix(255, 255, 255));
      add_row(dflt, mk_pix(0, 255, 0), 1, mk_pix(0, 255, 0));
      add_row(dflt, mk_pix(1, 2, 254), 0, none);
      add_row(dflt, mk_pix(128, 64, 32), 0, none);
      c = mk_cfg(100, 0, 0, 0);
      add_row(c, mk_pix(0, 0, 0), 1, mk_pix(255, 255, 255));
      add_row(c, mk_pix(77, 200, 1), 0, none);
      c = mk_cfg(100, 200, 0, 0);
      add_row(c, mk_pix(255, 0, 17), 0, none);
      add_row(c, mk_pix(128, 128, 128), 0, none);
      add_row(mk_cfg(100, 100, -100, 0), mk_pix(255, 255, 255), 1, mk_pix(0, 0, 0));
      add_row(mk_cfg(0, 100, 100, 0), mk_pix(0, 0, 0), 1, mk_pix(255, 255, 255));
      c = mk_cfg(255, 255, 127, 0);
      add_row(c, mk_pix(255, 255, 255), 1, mk_pix(255, 255, 255));
      add_row(c, mk_pix(3, 90, 200), 0, none);
      add_row(mk_cfg(0, 100, 0, 0), mk_pix(255, 17, 0), 1, mk_pix(0, 0, 0));
      c = mk_cfg(100, 100, 0, 1);
      add_row(c, mk_pix(0, 0, 0), 1, mk_pix(0, 0, 0));
      add_row(c, mk_pix(255, 128, 0), 1, mk_pix(255, 128, 0));
      add_row(c, mk_pix(10, 200, 99), 0, none);
      add_row(mk_cfg(100, 50, 0, 1), mk_pix(40, 20, 0), 0, none);
      add_row(mk_cfg(100, 100, 50, 1), mk_pix(0, 0, 0), 1, mk_pix(128, 128, 128));
      add_row(mk_cfg(200, 100, 0, 1), mk_pix(200, 100, 50), 0, none);
      add_row(mk_cfg(255, 0, -128, 1), mk_pix(90, 255, 3), 0, none);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_settings(dflt);

      foreach (rows[i]) begin
         if (rows[i].cfg != cur_cfg) begin
            drain();
            write_settings(rows[i].cfg);
         end
         send_pixel(rows[i].pix, rows[i].typed, rows[i].want);
      end

      // Random phases: extremes first, then random settings in and beyond range
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain();
         case (ph)
            0:       c = mk_cfg(0, 0, -100, 0);
            1:       c = mk_cfg(200, 200, 100, 1);
            2:       c = mk_cfg(255, 255, -128, 0);
            3:       c = mk_cfg(0, 0, 127, 1);
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  c = cfg_type'($urandom);
               end else begin
                  c = mk_cfg($urandom_range(0, 200), $urandom_range(0, 200),
                             int'($urandom_range(0, 200)) - 100, $urandom_range(0, 1));
               end
            end
         endcase
         write_settings(c);
         tx_idle = (ph % 3) != 2;
         rx_idle = (ph % 4) != 3;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_pixel(mk_pix(pick_channel(), pick_channel(), pick_channel()), 0, none);
      end

      drain();
      $display("Covered %0d pixels over %0d register settings, %0d results checked,",
               sent_count, phase_count, checked_count);
      $display("per-channel and luma modes with random gaps and back-pressure.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
sv/pgcb_pkg.sv
sv/pgcb_req_if.sv
sv/pgcb_rsp_if.sv
sv/pgcb_lane.sv
sv/pixel_gamma_contrast_brightness.sv
test/pixel_gamma_contrast_brightness_test.sv
